>>> sv/tpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpu_pkg: shared types and constants of the tracker pattern unpacker
// Beat payload types, register indexes, cell field positions and limits.
// ----------------------------------------------------------------------------
package tpu_pkg;

	// limits on the pattern geometry
	localparam int MAX_CHANNELS = 32;
	localparam int MAX_ROWS     = 256;
	localparam int CELL_FIELDS  = 5;

	// hardware counters are 5 and 8 bits wide
	localparam int CH_LIMIT  = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
	localparam int ROW_LIMIT = (MAX_ROWS < 256) ? MAX_ROWS : 256;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int CH_CNT_W    = 6;
	localparam int ROW_CNT_W   = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT     = 2'd1;

	localparam logic [CH_CNT_W-1:0]  CH_COUNT_RST  = 6'd1;
	localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 9'd64;

	// field positions within a cell
	localparam int FLD_NOTE   = 0;
	localparam int FLD_INSTR  = 1;
	localparam int FLD_VOLUME = 2;
	localparam int FLD_EFFECT = 3;
	localparam int FLD_PARAM  = 4;

	// packing codes
	localparam int             MASK_FLAG_BIT   = 7;
	localparam logic [4:0]     FULL_CELL_MASK  = 5'h1E;
	localparam logic [7:0]     EXT_EFFECT      = 8'h0E;
	localparam logic [7:0]     EXT_EFFECT_BASE = 8'd36;
	localparam logic [7:0]     NIBBLE_MASK     = 8'h0F;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] row_index;
		logic [4:0] channel_index;
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] effect_param;
		logic       last_cell;
	} cell_beat_t;

endpackage

>>> sv/tpu_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpu_stream_if: valid/ready stream channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tpu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/tracker_pattern_unpacker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pattern_unpacker_core: packed pattern byte stream to cells
// Rebuilds five-field cells from the packed byte stream, tags row/channel.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle, sustained, while the cell side drains.
// A cell is registered into the output register, or into the skid entry under a
//   stall, with the beat carrying its final byte (mask-only empty cells: the mask beat).
// A two-entry output stage (output register plus skid) keeps bytes flowing
//   through a cell-side stall until the skid fills; bytes stall once both are full.
// Reset (arst_n low): no cell open, row/channel 0, channel_count 1, row_count 64, output empty.
module tracker_pattern_unpacker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	tpu_stream_if.sink                          bytes,
	tpu_stream_if.source                        cells,
	input  logic                                cfg_we,
	input  logic [tpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tpu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [tpu_pkg::CH_CNT_W-1:0]  CH_LIM_V  = 6'(tpu_pkg::CH_LIMIT);
	localparam logic [tpu_pkg::ROW_CNT_W-1:0] ROW_LIM_V = 9'(tpu_pkg::ROW_LIMIT);

	// configuration registers
	logic [tpu_pkg::CH_CNT_W-1:0]  ch_count_q;
	logic [tpu_pkg::ROW_CNT_W-1:0] row_count_q;

	// cell assembly state
	logic       cell_open_q;
	logic [4:0] pend_q;
	logic [7:0] fld_q [tpu_pkg::CELL_FIELDS];
	logic [7:0] row_q;
	logic [4:0] chan_q;

	// output register and skid entry
	tpu_pkg::cell_beat_t out_q;
	logic                out_v_q;
	tpu_pkg::cell_beat_t skid_q;
	logic                skid_v_q;

	// next-state logic
	logic [7:0]                    b;
	logic                          in_fire;
	logic                          out_free;
	logic [4:0]                    pend_nx;
	logic [7:0]                    fld_nx [tpu_pkg::CELL_FIELDS];
	logic                          done;
	logic                          emit;
	logic [tpu_pkg::CH_CNT_W-1:0]  nch;
	logic [tpu_pkg::ROW_CNT_W-1:0] nrow;
	logic                          last_ch;
	logic                          last_row;
	tpu_pkg::cell_beat_t           cell_nx;

	assign b        = bytes.payload.data_byte;
	assign bytes.ready = !skid_v_q;
	assign in_fire  = bytes.valid && bytes.ready;
	assign out_free = !out_v_q || cells.ready;

	assign cells.valid   = out_v_q;
	assign cells.payload = out_q;

	// Field capture: a fresh cell starts from zero; a mask byte sets the
	// pending set, a plain byte is the note with the other four to follow.
	// Inside a cell the byte fills the lowest pending field.
	always_comb begin
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < tpu_pkg::CELL_FIELDS; k++) begin
			fld_nx[k] = cell_open_q ? fld_q[k] : 8'd0;
		end
		pend_nx = pend_q;
		if (!cell_open_q) begin
			if (b[tpu_pkg::MASK_FLAG_BIT]) begin
				pend_nx = b[4:0];
			end else begin
				fld_nx[tpu_pkg::FLD_NOTE] = b;
				pend_nx = tpu_pkg::FULL_CELL_MASK;
			end
		end else begin
			for (int k = 0; k < tpu_pkg::CELL_FIELDS; k++) begin
				if (pend_q[k] && !hit) begin
					fld_nx[k]  = b;
					pend_nx[k] = 1'b0;
					hit        = 1'b1;
				end
			end
		end
	end

	assign done = (pend_nx == 5'd0);
	assign emit = in_fire && done;

	// Effective counts: zero acts as one, oversize clamps to the limit.
	// A counter at or past the last position is treated as last.
	assign nch  = (ch_count_q == '0) ? 6'd1 :
		(ch_count_q > CH_LIM_V) ? CH_LIM_V : ch_count_q;
	assign nrow = (row_count_q == '0) ? 9'd1 :
		(row_count_q > ROW_LIM_V) ? ROW_LIM_V : row_count_q;
	assign last_ch  = (({1'b0, chan_q} + 6'd1) >= nch);
	assign last_row = (({1'b0, row_q} + 9'd1) >= nrow);

	// Cell assembly with the extended-effect remap.
	always_comb begin
		cell_nx.row_index     = row_q;
		cell_nx.channel_index = chan_q;
		cell_nx.note          = fld_nx[tpu_pkg::FLD_NOTE];
		cell_nx.instrument    = fld_nx[tpu_pkg::FLD_INSTR];
		cell_nx.volume        = fld_nx[tpu_pkg::FLD_VOLUME];
		cell_nx.effect        = fld_nx[tpu_pkg::FLD_EFFECT];
		cell_nx.effect_param  = fld_nx[tpu_pkg::FLD_PARAM];
		cell_nx.last_cell     = last_ch && last_row;
		if (fld_nx[tpu_pkg::FLD_EFFECT] == tpu_pkg::EXT_EFFECT) begin
			cell_nx.effect = tpu_pkg::EXT_EFFECT_BASE
				+ {4'd0, fld_nx[tpu_pkg::FLD_PARAM][7:4]};
			cell_nx.effect_param = fld_nx[tpu_pkg::FLD_PARAM] & tpu_pkg::NIBBLE_MASK;
		end
	end

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_count_q  <= tpu_pkg::CH_COUNT_RST;
			row_count_q <= tpu_pkg::ROW_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpu_pkg::REG_CHANNEL_COUNT: ch_count_q  <= cfg_data[tpu_pkg::CH_CNT_W-1:0];
				tpu_pkg::REG_ROW_COUNT:     row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell state and row/channel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_open_q <= 1'b0;
			pend_q      <= 5'd0;
			row_q       <= 8'd0;
			chan_q      <= 5'd0;
		end else if (in_fire) begin
			if (done) begin
				cell_open_q <= 1'b0;
				pend_q      <= 5'd0;
				if (last_ch) begin
					chan_q <= 5'd0;
					row_q  <= last_row ? 8'd0 : row_q + 8'd1;
				end else begin
					chan_q <= chan_q + 5'd1;
				end
			end else begin
				cell_open_q <= 1'b1;
				pend_q      <= pend_nx;
			end
		end
	end

	// field bytes: payload only, cleared logically when a cell opens
	always_ff @(posedge clk) begin
		if (in_fire && !done) begin
			for (int k = 0; k < tpu_pkg::CELL_FIELDS; k++) begin
				fld_q[k] <= fld_nx[k];
			end
		end
	end

	// output register with one skid entry; order is out_q then skid_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= emit;
			end
		end else if (emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (emit) begin
				out_q <= cell_nx;
			end
		end else if (emit) begin
			skid_q <= cell_nx;
		end
	end

`ifndef SYNTHESIS
	// skid only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid with empty output register");

	// an open cell always has fields pending; a closed one has none
	a_open_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cell_open_q |-> (pend_q != 5'd0))
		else $error("open cell with no pending fields");

	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_open_q |-> (pend_q == 5'd0))
		else $error("closed cell with pending fields");

	// last cell of the pattern wraps both counters
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cell_nx.last_cell) |=> (row_q == 8'd0 && chan_q == 5'd0))
		else $error("counters did not wrap after last cell");

	// a cell emitted into a stalled output lands in the skid entry
	a_emit_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !out_free) |=> skid_v_q)
		else $error("cell dropped under output stall");
`endif

endmodule
